// ===== rtl/core/qte_pkg.sv =====
// Shared widths, payload types and coefficient types of the quintic trajectory evaluator.
package qte_pkg;

   localparam int DW = 32;   // external data width, Q16.16
   localparam int TW = 31;   // time width, unsigned Q15.16
   localparam int KW = 40;   // width of a scaled coefficient such as 60a
   localparam int HW = 128;  // width of every Horner intermediate

   typedef logic signed [HW-1:0] wide_type;
   typedef logic signed [KW-1:0] coef_k_type;

   typedef struct packed {
      coef_k_type a;
      coef_k_type b;
      coef_k_type c;
      coef_k_type d;
      coef_k_type e;
      coef_k_type f;
      coef_k_type a5;
      coef_k_type b4;
      coef_k_type c3;
      coef_k_type d2;
      coef_k_type a20;
      coef_k_type b12;
      coef_k_type c6;
      coef_k_type a60;
      coef_k_type b24;
   } coef_type;

   typedef struct packed {
      coef_type        coef;
      logic [TW-1:0]   final_time;
      logic [1:0]      final_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [DW-1:0] sample_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [DW-1:0] position;
      logic signed [DW-1:0] velocity;
      logic signed [DW-1:0] acceleration;
      logic signed [DW-1:0] jerk;
      logic                 saturated;
   } rsp_payload_type;

   function automatic coef_k_type kext(input logic signed [DW-1:0] x);
      return {{(KW-DW){x[DW-1]}}, x};
   endfunction

   function automatic wide_type widen(input coef_k_type k);
      return {{(HW-KW){k[KW-1]}}, k};
   endfunction

endpackage

// ===== rtl/core/qte_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface qte_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ===== rtl/core/qte_csr.sv =====
// Configuration registers and the scaled coefficient sets of the derivatives.
module qte_csr
   import qte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic [2:0]    csr_index,
   input  logic [DW-1:0] csr_data,
   output cfg_type       cfg
);

   localparam logic [2:0] REG_COEF_A     = 3'd0;
   localparam logic [2:0] REG_COEF_B     = 3'd1;
   localparam logic [2:0] REG_COEF_C     = 3'd2;
   localparam logic [2:0] REG_COEF_D     = 3'd3;
   localparam logic [2:0] REG_COEF_E     = 3'd4;
   localparam logic [2:0] REG_COEF_F     = 3'd5;
   localparam logic [2:0] REG_FINAL_TIME = 3'd6;
   localparam logic [2:0] REG_FINAL_MODE = 3'd7;

   logic signed [DW-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff, coef_e_ff, coef_f_ff;
   logic signed [DW-1:0] coef_a_in, coef_b_in, coef_c_in, coef_d_in, coef_e_in, coef_f_in;
   logic [TW-1:0]        final_time_ff, final_time_in;
   logic [1:0]           final_mode_ff, final_mode_in;
   coef_k_type           ka, kb, kc, kd;

   always_comb begin
      coef_a_in     = coef_a_ff;
      coef_b_in     = coef_b_ff;
      coef_c_in     = coef_c_ff;
      coef_d_in     = coef_d_ff;
      coef_e_in     = coef_e_ff;
      coef_f_in     = coef_f_ff;
      final_time_in = final_time_ff;
      final_mode_in = final_mode_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_COEF_A:     coef_a_in     = csr_data;
            REG_COEF_B:     coef_b_in     = csr_data;
            REG_COEF_C:     coef_c_in     = csr_data;
            REG_COEF_D:     coef_d_in     = csr_data;
            REG_COEF_E:     coef_e_in     = csr_data;
            REG_COEF_F:     coef_f_in     = csr_data;
            REG_FINAL_TIME: final_time_in = csr_data[TW-1:0];
            REG_FINAL_MODE: final_mode_in = csr_data[1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff     <= '0;
         coef_b_ff     <= '0;
         coef_c_ff     <= '0;
         coef_d_ff     <= '0;
         coef_e_ff     <= '0;
         coef_f_ff     <= '0;
         final_time_ff <= '0;
         final_mode_ff <= '0;
      end else begin
         coef_a_ff     <= coef_a_in;
         coef_b_ff     <= coef_b_in;
         coef_c_ff     <= coef_c_in;
         coef_d_ff     <= coef_d_in;
         coef_e_ff     <= coef_e_in;
         coef_f_ff     <= coef_f_in;
         final_time_ff <= final_time_in;
         final_mode_ff <= final_mode_in;
      end
   end

   assign ka = kext(coef_a_ff);
   assign kb = kext(coef_b_ff);
   assign kc = kext(coef_c_ff);
   assign kd = kext(coef_d_ff);

   // Factors use shift, add, sub; user must change registers only while idle, unchecked here.
   always_comb begin
      cfg.coef.a   = ka;
      cfg.coef.b   = kb;
      cfg.coef.c   = kc;
      cfg.coef.d   = kd;
      cfg.coef.e   = kext(coef_e_ff);
      cfg.coef.f   = kext(coef_f_ff);
      cfg.coef.a5  = (ka <<< 2) + ka;
      cfg.coef.b4  = kb <<< 2;
      cfg.coef.c3  = (kc <<< 1) + kc;
      cfg.coef.d2  = kd <<< 1;
      cfg.coef.a20 = (ka <<< 4) + (ka <<< 2);
      cfg.coef.b12 = (kb <<< 3) + (kb <<< 2);
      cfg.coef.c6  = (kc <<< 2) + (kc <<< 1);
      cfg.coef.a60 = (ka <<< 6) - (ka <<< 2);
      cfg.coef.b24 = (kb <<< 4) + (kb <<< 3);
      cfg.final_time = final_time_ff;
      cfg.final_mode = final_mode_ff;
   end

endmodule

// ===== rtl/core/qte_pipe_ctrl.sv =====
// Valid bits and per-stage load enables of the evaluation pipeline.
module qte_pipe_ctrl #(
   parameter int STAGES = 17
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              out_ready,
   output logic [STAGES-1:0] en,
   output logic [STAGES-1:0] valid
);

   logic [STAGES-1:0] valid_ff, valid_in;

   // A stage may load when it is empty or when every stage after it moves on;
   // an empty stage further down lets the ones above it close the gap.
   for (genvar g = 0; g < STAGES; g++) begin : g_en
      assign en[g] = out_ready | ~(&valid_ff[STAGES-1:g]);
   end

   always_comb begin
      valid_in[0] = en[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign valid = valid_ff;

endmodule

// ===== rtl/core/qte_mac.sv =====
// One Horner step over two stages: h_out = floor(h_in * t_in / 2^FRAC) + k_in.
module qte_mac
   import qte_pkg::*;
#(
   parameter int FRAC = 16
) (
   input  logic          clock,
   input  logic          mul_en,
   input  logic          sum_en,
   input  wide_type      h_in,
   input  logic [TW-1:0] t_in,
   input  wide_type      k_in,
   output wide_type      h_out
);

   localparam int PW = HW + DW;

   logic [63:0]        pp0_ff, pp1_ff, pp2_ff, pp0_in, pp1_in, pp2_in;
   logic signed [63:0] pp3_ff, pp3_in;
   logic signed [31:0] top_limb;
   logic [PW-1:0]      a_w, b_w, k_w, sum_w;
   wide_type           h_ff, h_next;

   assign top_limb = h_in[HW-1:HW-DW];

   // Four 32 by 31 partial products; only the top limb carries the sign.
   always_comb begin
      pp0_in = h_in[31:0] * t_in;
      pp1_in = h_in[63:32] * t_in;
      pp2_in = h_in[95:64] * t_in;
      pp3_in = top_limb * $signed({1'b0, t_in});
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         pp0_ff <= pp0_in;
         pp1_ff <= pp1_in;
         pp2_ff <= pp2_in;
         pp3_ff <= pp3_in;
      end
   end

   // Even and odd limbs do not overlap, so the product is a single add of two words.
   // The constant goes in pre-shifted, which keeps the floor of the shifted sum exact.
   always_comb begin
      a_w    = {32'b0, pp2_ff, pp0_ff};
      b_w    = {pp3_ff, pp1_ff, 32'b0};
      k_w    = {{(DW-FRAC){k_in[HW-1]}}, k_in, {FRAC{1'b0}}};
      sum_w  = a_w + b_w + k_w;
      h_next = sum_w[FRAC +: HW];
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         h_ff <= h_next;
      end
   end

   assign h_out = h_ff;

endmodule

// ===== rtl/core/quintic_trajectory_evaluator.sv =====
// Top level of the quintic trajectory evaluator: clamp, Horner pipeline, extrapolation, saturation.
//
//   channel   direction   handshake           payload
//   req_if    in          valid / ready       sample_time
//   rsp_if    out         valid / ready       position, velocity, acceleration, jerk, saturated
//   csr_*     in          csr_write           csr_index, csr_data
//
// One sample enters per cycle; its result reaches the output register after the clamp stage,
// the five chained Horner steps of the position (two stages each: partial products, then sum),
// two extrapolation multiplies, a sum stage and a saturation stage. Reset clears the pipeline
// valid bits and all configuration.
// On a result stall, empty stages keep filling; input is refused only when all are full.
module quintic_trajectory_evaluator
   import qte_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic [2:0]    csr_index,
   input  logic [DW-1:0] csr_data,
   qte_stream_if.sink    req_if,
   qte_stream_if.source  rsp_if
);

   localparam int STAGES = 17;
   localparam int SIDE_N = 15;

   localparam logic [1:0] MODE_HOLD  = 2'd0;
   localparam logic [1:0] MODE_ACCEL = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic [TW-1:0] t;
      logic [TW-1:0] dt;
      logic          ext;
      logic          accm;
   } side_type;

   typedef struct packed {
      wide_type pos;
      wide_type vel;
      wide_type acc;
      wide_type jrk;
   } poly4_type;

   cfg_type           cfg;
   logic [STAGES-1:0] en, valid;

   side_type          side_in;
   side_type          side_ff [SIDE_N];
   logic [TW-1:0]     s_mag;
   logic              past_end;

   wide_type pos_s2, pos_s4, pos_s6, pos_s8, pos_s10;
   wide_type vel_s4, vel_s6, vel_s8, vel_s10;
   wide_type acc_s6, acc_s8, acc_s10;
   wide_type jrk_s8, jrk_s10;
   wide_type vterm_s12, w_s12, wterm_s14;
   wide_type vterm13_ff, vterm14_ff, w13_ff, w14_ff;
   wide_type k_zero;

   poly4_type       d10_w, d11_ff, d12_ff, d13_ff, d14_ff, fin15_ff, fin15_in;
   rsp_payload_type out_ff, out_in;
   logic [DW:0]     sp, sv, sa, sj;

   logic in_xfer, out_xfer;

   function automatic logic [DW:0] sat32(input wide_type x);
      logic fits;
      fits = (x[HW-1:DW-1] == '0) || (x[HW-1:DW-1] == '1);
      if (fits) begin
         return {1'b0, x[DW-1:0]};
      end else if (x[HW-1]) begin
         return {1'b1, Q_MIN};
      end else begin
         return {1'b1, Q_MAX};
      end
   endfunction

   qte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   qte_pipe_ctrl #(.STAGES(STAGES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .out_ready (rsp_if.ready),
      .en        (en),
      .valid     (valid)
   );

   assign req_if.ready = en[0];
   assign k_zero       = '0;

   // Stage 0: clamp the sample time and find the time past the end of the segment.
   always_comb begin
      s_mag        = req_if.payload.sample_time[TW-1:0];
      past_end     = !req_if.payload.sample_time[DW-1] && (s_mag > cfg.final_time);
      side_in.t    = req_if.payload.sample_time[DW-1] ? '0
                   : (past_end ? cfg.final_time : s_mag);
      side_in.dt   = past_end ? (s_mag - cfg.final_time) : '0;
      side_in.ext  = past_end && (cfg.final_mode != MODE_HOLD);
      side_in.accm = (cfg.final_mode == MODE_ACCEL) || (cfg.final_mode == MODE_SPARE);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= side_in;
      end
   end

   for (genvar g = 1; g < SIDE_N; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[g]) begin
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   // The four polynomials are staggered so that they all finish at stage 10.
   qte_mac u_pos1 (.clock(clock), .mul_en(en[1]), .sum_en(en[2]), .h_in(widen(cfg.coef.a)),
                   .t_in(side_ff[0].t), .k_in(widen(cfg.coef.b)), .h_out(pos_s2));
   qte_mac u_pos2 (.clock(clock), .mul_en(en[3]), .sum_en(en[4]), .h_in(pos_s2),
                   .t_in(side_ff[2].t), .k_in(widen(cfg.coef.c)), .h_out(pos_s4));
   qte_mac u_pos3 (.clock(clock), .mul_en(en[5]), .sum_en(en[6]), .h_in(pos_s4),
                   .t_in(side_ff[4].t), .k_in(widen(cfg.coef.d)), .h_out(pos_s6));
   qte_mac u_pos4 (.clock(clock), .mul_en(en[7]), .sum_en(en[8]), .h_in(pos_s6),
                   .t_in(side_ff[6].t), .k_in(widen(cfg.coef.e)), .h_out(pos_s8));
   qte_mac u_pos5 (.clock(clock), .mul_en(en[9]), .sum_en(en[10]), .h_in(pos_s8),
                   .t_in(side_ff[8].t), .k_in(widen(cfg.coef.f)), .h_out(pos_s10));

   qte_mac u_vel1 (.clock(clock), .mul_en(en[3]), .sum_en(en[4]), .h_in(widen(cfg.coef.a5)),
                   .t_in(side_ff[2].t), .k_in(widen(cfg.coef.b4)), .h_out(vel_s4));
   qte_mac u_vel2 (.clock(clock), .mul_en(en[5]), .sum_en(en[6]), .h_in(vel_s4),
                   .t_in(side_ff[4].t), .k_in(widen(cfg.coef.c3)), .h_out(vel_s6));
   qte_mac u_vel3 (.clock(clock), .mul_en(en[7]), .sum_en(en[8]), .h_in(vel_s6),
                   .t_in(side_ff[6].t), .k_in(widen(cfg.coef.d2)), .h_out(vel_s8));
   qte_mac u_vel4 (.clock(clock), .mul_en(en[9]), .sum_en(en[10]), .h_in(vel_s8),
                   .t_in(side_ff[8].t), .k_in(widen(cfg.coef.e)), .h_out(vel_s10));

   qte_mac u_acc1 (.clock(clock), .mul_en(en[5]), .sum_en(en[6]), .h_in(widen(cfg.coef.a20)),
                   .t_in(side_ff[4].t), .k_in(widen(cfg.coef.b12)), .h_out(acc_s6));
   qte_mac u_acc2 (.clock(clock), .mul_en(en[7]), .sum_en(en[8]), .h_in(acc_s6),
                   .t_in(side_ff[6].t), .k_in(widen(cfg.coef.c6)), .h_out(acc_s8));
   qte_mac u_acc3 (.clock(clock), .mul_en(en[9]), .sum_en(en[10]), .h_in(acc_s8),
                   .t_in(side_ff[8].t), .k_in(widen(cfg.coef.d2)), .h_out(acc_s10));

   qte_mac u_jrk1 (.clock(clock), .mul_en(en[7]), .sum_en(en[8]), .h_in(widen(cfg.coef.a60)),
                   .t_in(side_ff[6].t), .k_in(widen(cfg.coef.b24)), .h_out(jrk_s8));
   qte_mac u_jrk2 (.clock(clock), .mul_en(en[9]), .sum_en(en[10]), .h_in(jrk_s8),
                   .t_in(side_ff[8].t), .k_in(widen(cfg.coef.c6)), .h_out(jrk_s10));

   // Extrapolation terms: v*dt, w = acc*dt, then w*dt / 2 for the position.
   qte_mac #(.FRAC(16)) u_vterm (.clock(clock), .mul_en(en[11]), .sum_en(en[12]),
                                 .h_in(vel_s10), .t_in(side_ff[10].dt), .k_in(k_zero),
                                 .h_out(vterm_s12));
   qte_mac #(.FRAC(16)) u_wacc (.clock(clock), .mul_en(en[11]), .sum_en(en[12]),
                                .h_in(acc_s10), .t_in(side_ff[10].dt), .k_in(k_zero),
                                .h_out(w_s12));
   qte_mac #(.FRAC(17)) u_wterm (.clock(clock), .mul_en(en[13]), .sum_en(en[14]),
                                 .h_in(w_s12), .t_in(side_ff[12].dt), .k_in(k_zero),
                                 .h_out(wterm_s14));

   assign d10_w = '{pos: pos_s10, vel: vel_s10, acc: acc_s10, jrk: jrk_s10};

   always_ff @(posedge clock) begin
      if (en[11]) begin
         d11_ff <= d10_w;
      end
      if (en[12]) begin
         d12_ff <= d11_ff;
      end
      if (en[13]) begin
         d13_ff     <= d12_ff;
         vterm13_ff <= vterm_s12;
         w13_ff     <= w_s12;
      end
      if (en[14]) begin
         d14_ff     <= d13_ff;
         vterm14_ff <= vterm13_ff;
         w14_ff     <= w13_ff;
      end
   end

   // Stage 15: apply the extrapolation selected by the final mode.
   always_comb begin
      fin15_in     = d14_ff;
      fin15_in.pos = d14_ff.pos
                   + (side_ff[14].ext ? vterm14_ff : k_zero)
                   + ((side_ff[14].ext && side_ff[14].accm) ? wterm_s14 : k_zero);
      fin15_in.vel = d14_ff.vel
                   + ((side_ff[14].ext && side_ff[14].accm) ? w14_ff : k_zero);
   end

   always_ff @(posedge clock) begin
      if (en[15]) begin
         fin15_ff <= fin15_in;
      end
   end

   // Stage 16: clip to the 32 bit range and hold the result for the consumer.
   always_comb begin
      sp = sat32(fin15_ff.pos);
      sv = sat32(fin15_ff.vel);
      sa = sat32(fin15_ff.acc);
      sj = sat32(fin15_ff.jrk);
      out_in.position     = sp[DW-1:0];
      out_in.velocity     = sv[DW-1:0];
      out_in.acceleration = sa[DW-1:0];
      out_in.jerk         = sj[DW-1:0];
      out_in.saturated    = sp[DW] | sv[DW] | sa[DW] | sj[DW];
   end

   always_ff @(posedge clock) begin
      if (en[16]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid   = valid[STAGES-1];
   assign rsp_if.payload = out_ff;

   assign in_xfer  = req_if.valid & req_if.ready;
   assign out_xfer = rsp_if.valid & rsp_if.ready;

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      ((&valid) && !rsp_if.ready) |-> !req_if.ready)
      else $error("input taken while every pipeline stage is full and stalled");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid) ==
                $past($countones(valid)) + $past(in_xfer) - $past(out_xfer)))
      else $error("items in flight do not match the transfers in and out");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.payload.saturated) |->
         (rsp_if.payload.position == Q_MAX || rsp_if.payload.position == Q_MIN ||
          rsp_if.payload.velocity == Q_MAX || rsp_if.payload.velocity == Q_MIN ||
          rsp_if.payload.acceleration == Q_MAX || rsp_if.payload.acceleration == Q_MIN ||
          rsp_if.payload.jerk == Q_MAX || rsp_if.payload.jerk == Q_MIN))
      else $error("saturation flagged but no output is at a range limit");

endmodule
